>>> sv/arpc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ARP cache package
// Shared types and constants for the ARP cache table.
// ----------------------------------------------------------------------------
package arpc_pkg;
    localparam int TIME_W = 48;
    localparam int IP_W   = 32;
    localparam int MAC_W  = 48;
    localparam int REG_W  = 34;

    localparam logic [1:0] OP_UPDATE = 2'd0;
    localparam logic [1:0] OP_LK_IP  = 2'd1;
    localparam logic [1:0] OP_LK_MAC = 2'd2;
    localparam logic [1:0] OP_SWEEP  = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_MISS     = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_CONFLICT = 2'd3;

    localparam logic [0:0] CFG_LIFETIME = 1'd0;
    localparam logic [0:0] CFG_INTERVAL = 1'd1;

    localparam logic [REG_W-1:0] LIFETIME_RST = 34'd14400000000;
    localparam logic [REG_W-1:0] INTERVAL_RST = 34'd10000000;

    typedef struct packed {
        logic [IP_W-1:0]   ip;
        logic [MAC_W-1:0]  mac;
        logic              lrn;
        logic [TIME_W-1:0] exp;
    } t_entry;

    function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] t,
                                                  input logic [REG_W-1:0] d);
        logic [TIME_W:0] s;
        s = {1'b0, t} + {{(TIME_W+1-REG_W){1'b0}}, d};
        return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
    endfunction
endpackage

>>> sv/arpc_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ARP cache entry memory
// Single-port-write, one-read synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module arpc_mem #(
    parameter int ENTRIES = 32,
    parameter int AW = 5
) (
    input  logic               i_clk,
    input  logic               i_we,
    input  logic [AW-1:0]      i_waddr,
    input  arpc_pkg::t_entry   i_wdata,
    input  logic [AW-1:0]      i_raddr,
    output arpc_pkg::t_entry   o_rdata
);
    arpc_pkg::t_entry r_mem [ENTRIES];
    arpc_pkg::t_entry r_rd;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rd <= r_mem[i_raddr];
    end
    assign o_rdata = r_rd;
endmodule

>>> sv/arp_cache_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ARP cache table
// IPv4 to MAC cache with expiry sweep, update and lookups.
// ----------------------------------------------------------------------------
// One request at a time. Entries sit in a single synchronous RAM, and each
// slot is read by presenting its address, then checking its data. When a
// sweep is due it walks the valid entries; each expired entry is removed
// and, unless it is the last one, its slot is refilled from the last slot.
// For lookups and updates the search then walks the slots from the first,
// followed by the output state. A waiting result only holds the output
// register, so the next request is taken and worked on meanwhile, up to its
// own output state. No reset clearing pass is needed since only slots below
// the fill count are read.
module arp_cache_table #(
    parameter int ENTRIES = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_opcode,
    input  logic [47:0] i_now_time,
    input  logic [31:0] i_ip_addr,
    input  logic [47:0] i_mac_addr,
    input  logic        i_learned,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_status,
    output logic [47:0] o_found_mac,
    output logic [31:0] o_found_ip,
    output logic        o_found_learned,
    output logic [5:0]  o_entries_used,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [0:0]  i_cfg_index,
    input  logic [33:0] i_cfg_data
);
    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SWRD  = 4'd1;
    localparam logic [3:0] S_SWCHK = 4'd2;
    localparam logic [3:0] S_MVRD  = 4'd3;
    localparam logic [3:0] S_MVWR  = 4'd4;
    localparam logic [3:0] S_SRD   = 4'd5;
    localparam logic [3:0] S_SCHK  = 4'd6;
    localparam logic [3:0] S_OUT   = 4'd7;

    logic [3:0]  r_st, n_st;
    logic [CW-1:0] r_cnt, n_cnt, r_idx, n_idx;
    logic [47:0] r_nsweep, n_nsweep;
    logic [33:0] r_life, r_intv;
    logic [1:0]  r_op;
    logic [47:0] r_now, r_mac;
    logic [31:0] r_ip;
    logic        r_lrn;
    logic        r_ov, n_ov;
    logic [1:0]  r_stat, n_stat;
    arpc_pkg::t_entry r_res, n_res;

    logic             we;
    logic [AW-1:0]    waddr, raddr;
    arpc_pkg::t_entry wdata, rdata;
    logic [CW-1:0]    last;

    arpc_mem #(.ENTRIES(ENTRIES), .AW(AW)) u_mem (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(raddr), .o_rdata(rdata)
    );

    assign o_ready     = (r_st == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign last        = r_cnt - CW'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_life <= arpc_pkg::LIFETIME_RST;
            r_intv <= arpc_pkg::INTERVAL_RST;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == arpc_pkg::CFG_LIFETIME) begin
                r_life <= i_cfg_data;
            end else begin
                r_intv <= i_cfg_data;
            end
        end
    end

    always_comb begin
        n_st = r_st; n_cnt = r_cnt; n_idx = r_idx; n_nsweep = r_nsweep;
        n_ov = r_ov; n_stat = r_stat; n_res = r_res;
        we = 1'b0; waddr = r_idx[AW-1:0]; raddr = r_idx[AW-1:0];
        wdata = rdata;
        if (r_ov && i_ready) begin
            n_ov = 1'b0;
        end
        case (r_st)
            S_IDLE: begin
                if (i_valid && o_ready) begin
                    n_idx = '0;
                    n_res = '0;
                    if (i_now_time >= r_nsweep) begin
                        n_st = S_SWRD;
                        n_nsweep = arpc_pkg::sat_add(i_now_time, r_intv);
                    end else begin
                        n_st = S_SRD;
                    end
                end
            end
            S_SWRD: begin
                n_st = (r_idx < r_cnt) ? S_SWCHK : S_SRD;
                if (r_idx >= r_cnt) n_idx = '0;
            end
            S_SWCHK: begin
                if (rdata.exp > r_now) begin
                    n_idx = r_idx + CW'(1);
                    n_st = S_SWRD;
                end else begin
                    n_cnt = last;
                    n_st = (r_idx != last) ? S_MVRD : S_SWRD;
                    raddr = last[AW-1:0];
                end
            end
            S_MVRD: begin
                raddr = r_cnt[AW-1:0];
                n_st = S_MVWR;
            end
            S_MVWR: begin
                we = 1'b1;
                n_st = S_SWRD;
            end
            S_SRD: begin
                if (r_op == arpc_pkg::OP_SWEEP) begin
                    n_stat = arpc_pkg::ST_OK; n_st = S_OUT;
                end else if (r_idx < r_cnt) begin
                    n_st = S_SCHK;
                end else if (r_op == arpc_pkg::OP_UPDATE) begin
                    if (r_cnt >= CW'(ENTRIES)) begin
                        n_stat = arpc_pkg::ST_FULL;
                    end else begin
                        n_stat = arpc_pkg::ST_OK;
                        we = 1'b1;
                        waddr = r_cnt[AW-1:0];
                        wdata.ip = r_ip; wdata.mac = r_mac; wdata.lrn = r_lrn;
                        wdata.exp = arpc_pkg::sat_add(r_now, r_life);
                        n_res = wdata;
                        n_cnt = r_cnt + CW'(1);
                    end
                    n_st = S_OUT;
                end else begin
                    n_stat = arpc_pkg::ST_MISS; n_st = S_OUT;
                end
            end
            S_SCHK: begin
                if ((r_op != arpc_pkg::OP_LK_MAC && rdata.ip == r_ip) ||
                    (r_op == arpc_pkg::OP_LK_MAC && rdata.mac == r_mac)) begin
                    n_st = S_OUT;
                    n_stat = arpc_pkg::ST_OK;
                    n_res = rdata;
                    if (r_op == arpc_pkg::OP_UPDATE) begin
                        if (r_lrn && !rdata.lrn) begin
                            n_stat = arpc_pkg::ST_CONFLICT;
                        end else begin
                            we = 1'b1;
                            wdata.mac = r_mac;
                            wdata.exp = arpc_pkg::sat_add(r_now, r_life);
                            n_res = wdata;
                        end
                    end
                end else begin
                    n_idx = r_idx + CW'(1);
                    raddr = n_idx[AW-1:0];
                    n_st = S_SRD;
                end
            end
            S_OUT: begin
                if (!r_ov || i_ready) begin
                    n_ov = 1'b1;
                    n_st = S_IDLE;
                end
            end
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_cnt <= '0; r_nsweep <= '0; r_ov <= 1'b0;
        end else begin
            r_st <= n_st; r_cnt <= n_cnt; r_nsweep <= n_nsweep; r_ov <= n_ov;
        end
        r_idx <= n_idx; r_stat <= n_stat; r_res <= n_res;
        if (i_valid && o_ready) begin
            r_op <= i_opcode; r_now <= i_now_time; r_ip <= i_ip_addr;
            r_mac <= i_mac_addr; r_lrn <= i_learned;
        end
        if (r_st == S_OUT && (!r_ov || i_ready)) begin
            o_status <= r_stat;
            o_found_mac <= r_res.mac;
            o_found_ip <= r_res.ip;
            o_found_learned <= r_res.lrn;
            o_entries_used <= 6'(r_cnt);
        end
    end

    assign o_valid = r_ov;
endmodule

>>> sv/arpc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ARP cache port checker
// Port-level properties of the ARP cache table.
// ----------------------------------------------------------------------------
module arpc_props (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [1:0]  o_status,
    input logic [47:0] o_found_mac,
    input logic [31:0] o_found_ip,
    input logic [5:0]  o_entries_used
);
    a_used_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_entries_used <= 6'd32) else $error("count over depth");
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == arpc_pkg::ST_MISS || o_status == arpc_pkg::ST_FULL)
        |-> o_found_mac == '0 && o_found_ip == '0) else $error("miss data");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_status)) else $error("out drop");
    a_one_at_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready) else $error("double accept");
endmodule

bind arp_cache_table arpc_props u_chk (.*);
